// ----- src/tlqs_pkg.sv -----
package tlqs_pkg;

	localparam int TASK_ID_W  = 4;
	localparam int NUM_IDS    = 16;
	localparam int OP_W       = 3;
	localparam int BURST_W    = 16;
	localparam int IO_W       = 4;
	localparam int THR_W      = 16;
	localparam int SLICE_W    = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int SHARE_W    = 3;

	localparam int MAX_TASKS_DEF = 16;

	localparam logic [THR_W-1:0]   THR_RESET   = 16'd5;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd2;

	// foreground turns per share cycle, and the last count before wrap
	localparam logic [SHARE_W-1:0] FORE_TURNS = 3'd4;
	localparam logic [SHARE_W-1:0] SHARE_LAST = 3'd4;

	typedef enum logic [OP_W-1:0] {
		OP_ARRIVE   = 3'd0,
		OP_REQUEUE  = 3'd1,
		OP_COMPLETE = 3'd2,
		OP_BLOCK    = 3'd3,
		OP_TICK     = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_THRESHOLD = 1'b0,
		REG_SLICE_LENGTH   = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PICK,
		ST_ROTATE,
		ST_LOAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic arrive;
		logic requeue;
		logic share_inc;
		logic share_adv;
		logic slice_inc;
		logic slice_zero;
		logic pick;
		logic rotate;
		logic load;
		logic publish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic id_ok;
		logic running;
		logic slice_hit;
		logic pick_found;
		logic turn_found;
		logic out_busy;
	} stat_t;

endpackage

// ----- src/tlqs_ram.sv -----
module tlqs_ram #(
	parameter int WIDTH = tlqs_pkg::TASK_ID_W,
	parameter int DEPTH = tlqs_pkg::MAX_TASKS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/tlqs_ctrl.sv -----
module tlqs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            event_valid,
	output logic            event_stall,
	input  tlqs_pkg::stat_t st,
	output tlqs_pkg::cmd_t  cmd
);

	import tlqs_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (event_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				case (st.op)
					OP_COMPLETE, OP_BLOCK: begin
						state_next = st.running ? ST_PICK : ST_DONE;
					end
					OP_TICK: begin
						if (!st.running) state_next = ST_PICK;
						else if (st.slice_hit) state_next = ST_ROTATE;
						else state_next = ST_DONE;
					end
					default: state_next = ST_DONE;
				endcase
			end
			ST_PICK: begin
				state_next = st.pick_found ? ST_LOAD : ST_DONE;
			end
			ST_ROTATE: begin
				state_next = st.turn_found ? ST_LOAD : ST_DONE;
			end
			ST_LOAD: begin
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (!st.out_busy) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		event_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.latch = event_valid;
			end
			ST_EXEC: begin
				case (st.op)
					OP_ARRIVE:   cmd.arrive = st.id_ok;
					OP_REQUEUE:  cmd.requeue = st.id_ok;
					OP_COMPLETE: cmd.share_inc = st.running;
					OP_BLOCK:    cmd.share_adv = st.running;
					OP_TICK: begin
						if (st.running && st.slice_hit) begin
							cmd.share_adv  = 1'b1;
							cmd.slice_zero = 1'b1;
						end else if (st.running) begin
							cmd.slice_inc = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_PICK:   cmd.pick = 1'b1;
			ST_ROTATE: cmd.rotate = 1'b1;
			ST_LOAD:   cmd.load = 1'b1;
			ST_DONE:   cmd.publish = !st.out_busy;
			default: ;
		endcase
	end

endmodule

// ----- src/tlqs_datapath.sv -----
module tlqs_datapath #(
	parameter int MAX_TASKS = tlqs_pkg::MAX_TASKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlqs_pkg::cmd_t                    cmd,
	output tlqs_pkg::stat_t                   st,
	input  logic [tlqs_pkg::OP_W-1:0]         op,
	input  logic [tlqs_pkg::TASK_ID_W-1:0]    task_id,
	input  logic [tlqs_pkg::BURST_W-1:0]      burst_total,
	input  logic [tlqs_pkg::IO_W-1:0]         io_count,
	input  logic                              cfg_we,
	input  logic [tlqs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlqs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              status_stall,
	output logic                              status_valid,
	output logic                              running_valid,
	output logic [tlqs_pkg::TASK_ID_W-1:0]    running_id,
	output logic                              running_class,
	output logic                              fore_empty,
	output logic                              back_empty,
	output logic                              dropped
);

	import tlqs_pkg::*;

	localparam int PTR_W  = $clog2(MAX_TASKS);
	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int PROD_W = THR_W + IO_W + 1;

	// latched event word
	op_t                  op_q;
	logic [TASK_ID_W-1:0] id_q;
	logic [BURST_W-1:0]   burst_q;
	logic [IO_W-1:0]      io_q;

	logic [THR_W-1:0]   thr_q;
	logic [SLICE_W-1:0] slen_q;

	logic [PTR_W-1:0] fore_head_q, back_head_q;
	logic [CNT_W-1:0] fore_cnt_q, back_cnt_q;
	logic             sel_fore_q;

	logic [TASK_ID_W-1:0] run_task_q;
	logic                 run_flag_q;
	logic                 run_class_q;
	logic [SHARE_W-1:0]   share_q;
	logic [SLICE_W-1:0]   slice_q;
	logic                 drop_q;
	logic                 class_q [NUM_IDS];

	logic                 out_valid_q;
	logic                 out_rv_q;
	logic [TASK_ID_W-1:0] out_id_q;
	logic                 out_class_q;
	logic                 out_fe_q;
	logic                 out_be_q;
	logic                 out_drop_q;

	logic [TASK_ID_W-1:0] fore_rdata, back_rdata, pop_id;
	logic [TASK_ID_W-1:0] cls_raddr;
	logic                 cls_rd;
	logic                 fore_nz, back_nz, share_lt, turn_nz;
	logic [IO_W:0]        ios_plus;
	logic [PROD_W-1:0]    limit;
	logic                 class_new;
	logic                 push_en, push_fore, push_ok;
	logic [TASK_ID_W-1:0] push_id;
	logic                 pop_en, pop_fore;
	logic                 fore_we, back_we;
	logic [SUM_W-1:0]     fore_sum, back_sum;
	logic [PTR_W-1:0]     fore_tail, back_tail;
	logic [SHARE_W-1:0]   share_inc;

	assign fore_nz  = (fore_cnt_q != '0);
	assign back_nz  = (back_cnt_q != '0);
	assign share_lt = (share_q < FORE_TURNS);
	assign turn_nz  = share_lt ? fore_nz : back_nz;
	assign share_inc = (share_q == SHARE_LAST) ? '0 : share_q + 1'b1;

	// classification: long when burst exceeds threshold times (io count + 1)
	assign ios_plus  = {1'b0, io_q} + 1'b1;
	assign limit     = PROD_W'(thr_q) * PROD_W'(ios_plus);
	assign class_new = !(PROD_W'(burst_q) > limit);

	assign pop_id    = sel_fore_q ? fore_rdata : back_rdata;
	assign cls_raddr = cmd.load ? pop_id : id_q;
	assign cls_rd    = class_q[cls_raddr];

	always_comb begin
		push_en   = 1'b0;
		push_fore = 1'b0;
		push_id   = id_q;
		if (cmd.arrive) begin
			push_en   = 1'b1;
			push_fore = class_new;
		end else if (cmd.requeue) begin
			push_en   = 1'b1;
			push_fore = cls_rd;
		end else if (cmd.rotate && turn_nz) begin
			push_en   = 1'b1;
			push_fore = run_class_q;
			push_id   = run_task_q;
		end
	end

	assign push_ok = push_fore ? (fore_cnt_q != CNT_W'(MAX_TASKS))
	                           : (back_cnt_q != CNT_W'(MAX_TASKS));
	assign fore_we = push_en && push_ok && push_fore;
	assign back_we = push_en && push_ok && !push_fore;

	always_comb begin
		pop_en   = 1'b0;
		pop_fore = 1'b0;
		if (cmd.pick) begin
			pop_en   = fore_nz || back_nz;
			pop_fore = share_lt ? fore_nz : !back_nz;
		end else if (cmd.rotate) begin
			pop_en   = turn_nz;
			pop_fore = share_lt;
		end
	end

	assign fore_sum  = SUM_W'(fore_head_q) + SUM_W'(fore_cnt_q);
	assign back_sum  = SUM_W'(back_head_q) + SUM_W'(back_cnt_q);
	assign fore_tail = (fore_sum >= SUM_W'(MAX_TASKS)) ?
		PTR_W'(fore_sum - SUM_W'(MAX_TASKS)) : PTR_W'(fore_sum);
	assign back_tail = (back_sum >= SUM_W'(MAX_TASKS)) ?
		PTR_W'(back_sum - SUM_W'(MAX_TASKS)) : PTR_W'(back_sum);

	tlqs_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_fore_ram (
		.clk   (clk),
		.we    (fore_we),
		.waddr (fore_tail),
		.wdata (push_id),
		.raddr (fore_head_q),
		.rdata (fore_rdata)
	);

	tlqs_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_back_ram (
		.clk   (clk),
		.we    (back_we),
		.waddr (back_tail),
		.wdata (push_id),
		.raddr (back_head_q),
		.rdata (back_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op_t'(op);
			id_q    <= task_id;
			burst_q <= burst_total;
			io_q    <= io_count;
		end
		if (cmd.arrive) begin
			class_q[id_q] <= class_new;
		end
		if (cmd.publish) begin
			out_rv_q    <= run_flag_q;
			out_id_q    <= run_flag_q ? run_task_q : '0;
			out_class_q <= run_flag_q && run_class_q;
			out_fe_q    <= !fore_nz;
			out_be_q    <= !back_nz;
			out_drop_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			slen_q <= SLICE_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LONG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				REG_SLICE_LENGTH:   slen_q <= cfg_data[SLICE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_head_q <= '0;
			back_head_q <= '0;
			fore_cnt_q  <= '0;
			back_cnt_q  <= '0;
			sel_fore_q  <= 1'b0;
		end else begin
			fore_cnt_q <= fore_cnt_q + CNT_W'(fore_we) - CNT_W'(pop_en && pop_fore);
			back_cnt_q <= back_cnt_q + CNT_W'(back_we) - CNT_W'(pop_en && !pop_fore);
			if (pop_en) begin
				sel_fore_q <= pop_fore;
				if (pop_fore) begin
					fore_head_q <= (fore_head_q == PTR_W'(MAX_TASKS - 1)) ?
						'0 : fore_head_q + 1'b1;
				end else begin
					back_head_q <= (back_head_q == PTR_W'(MAX_TASKS - 1)) ?
						'0 : back_head_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_task_q  <= '0;
			run_flag_q  <= 1'b0;
			run_class_q <= 1'b0;
			share_q     <= '0;
			slice_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				drop_q <= 1'b0;
			end else if (push_en && !push_ok) begin
				drop_q <= 1'b1;
			end

			// keep the running class in step with the table
			if (cmd.arrive && (id_q == run_task_q)) begin
				run_class_q <= class_new;
			end

			if (cmd.share_inc) begin
				share_q <= share_inc;
			end else if (cmd.share_adv) begin
				share_q <= run_class_q ? share_inc : '0;
			end else if (cmd.load && !cls_rd) begin
				share_q <= '0;
			end

			if (cmd.slice_inc) begin
				slice_q <= slice_q + 1'b1;
			end else if (cmd.slice_zero || cmd.pick) begin
				slice_q <= '0;
			end else if (cmd.rotate && !turn_nz) begin
				slice_q <= SLICE_W'(1);
			end else if (cmd.load && (op_q == OP_TICK)) begin
				slice_q <= SLICE_W'(1);
			end

			if (cmd.pick && !(fore_nz || back_nz)) begin
				run_flag_q <= 1'b0;
				run_task_q <= '0;
			end else if (cmd.load) begin
				run_flag_q  <= 1'b1;
				run_task_q  <= pop_id;
				run_class_q <= cls_rd;
			end

			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!status_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st            = '0;
		st.op         = op_q;
		st.id_ok      = (32'(id_q) < MAX_TASKS);
		st.running    = run_flag_q;
		st.slice_hit  = (slice_q == slen_q);
		st.pick_found = fore_nz || back_nz;
		st.turn_found = turn_nz;
		st.out_busy   = out_valid_q && status_stall;
	end

	assign status_valid  = out_valid_q;
	assign running_valid = out_rv_q;
	assign running_id    = out_id_q;
	assign running_class = out_class_q;
	assign fore_empty    = out_fe_q;
	assign back_empty    = out_be_q;
	assign dropped       = out_drop_q;

endmodule

// ----- src/two_level_queue_scheduler.sv -----
// channel   direction  handshake                    word
// event     in         event_valid / event_stall    op, task_id, burst_total, io_count
// status    out        status_valid / status_stall  running_valid .. dropped
// config    in         cfg_we                       cfg_index, cfg_data
//
// an event passes through the states idle, exec and done (enqueue, tick inside the slice, complete or
// block while idle, unused codes); a pick or slice expiry also passes through pick or rotate, and one
// that dequeues through load as well: one step per state, and a dequeue waits for the ram read.
// reset clears queue counts, the running task and counters; queue rams and class table are unset.
// event_stall stays high until the status word is written to its register, and that
// write waits while the previous word is still held by status_stall.
module two_level_queue_scheduler #(
	parameter int MAX_TASKS = tlqs_pkg::MAX_TASKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              event_valid,
	output logic                              event_stall,
	input  logic [tlqs_pkg::OP_W-1:0]         op,
	input  logic [tlqs_pkg::TASK_ID_W-1:0]    task_id,
	input  logic [tlqs_pkg::BURST_W-1:0]      burst_total,
	input  logic [tlqs_pkg::IO_W-1:0]         io_count,
	output logic                              status_valid,
	input  logic                              status_stall,
	output logic                              running_valid,
	output logic [tlqs_pkg::TASK_ID_W-1:0]    running_id,
	output logic                              running_class,
	output logic                              fore_empty,
	output logic                              back_empty,
	output logic                              dropped,
	input  logic                              cfg_we,
	input  logic [tlqs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlqs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import tlqs_pkg::*;

	cmd_t  cmd;
	stat_t st;

	tlqs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.st          (st),
		.cmd         (cmd)
	);

	tlqs_datapath #(.MAX_TASKS(MAX_TASKS)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.op            (op),
		.task_id       (task_id),
		.burst_total   (burst_total),
		.io_count      (io_count),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.status_stall  (status_stall),
		.status_valid  (status_valid),
		.running_valid (running_valid),
		.running_id    (running_id),
		.running_class (running_class),
		.fore_empty    (fore_empty),
		.back_empty    (back_empty),
		.dropped       (dropped)
	);

	// one event in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && !event_stall) |=> event_stall)
		else $error("event taken while another is in flight");

	a_latch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |-> (event_valid && !event_stall))
		else $error("event word latched without a handshake");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !st.out_busy)
		else $error("status word overwritten while stalled");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(status_valid && !running_valid) |-> (running_id == '0 && !running_class))
		else $error("idle status carries a task");

endmodule

// ----- tb/tb_two_level_queue_scheduler.sv -----
`timescale 1ns / 100ps

module tb_two_level_queue_scheduler;
	import tlqs_pkg::*;

	// op codes the block leaves unused, still driven to check they change nothing
	localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

	localparam int DIRECTED_ROWS = 25;
	localparam int HOLD_CYCLES   = 400;
	localparam int TAIL_CYCLES   = 40;
	localparam int REPORT_LIMIT  = 40;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [TASK_ID_W-1:0] task_id;
		logic [BURST_W-1:0]   burst_total;
		logic [IO_W-1:0]      io_count;
	} sched_event_t;

	typedef struct packed {
		logic                 running_valid;
		logic [TASK_ID_W-1:0] running_id;
		logic                 running_class;
		logic                 fore_empty;
		logic                 back_empty;
		logic                 dropped;
	} status_word_t;

	typedef struct packed {
		sched_event_t ev;
		logic         typed;
		status_word_t want;
	} directed_row_t;

	typedef enum {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

	localparam status_word_t IDLE_ALL = '{1'b0, 4'd0, 1'b0, 1'b1, 1'b1, 1'b0};

	logic                  clk;
	logic                  arst_n;
	logic                  event_valid;
	logic                  event_stall;
	logic [OP_W-1:0]       op;
	logic [TASK_ID_W-1:0]  task_id;
	logic [BURST_W-1:0]    burst_total;
	logic [IO_W-1:0]       io_count;
	logic                  status_valid;
	logic                  status_stall;
	logic                  running_valid;
	logic [TASK_ID_W-1:0]  running_id;
	logic                  running_class;
	logic                  fore_empty;
	logic                  back_empty;
	logic                  dropped;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	two_level_queue_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.op           (op),
		.task_id      (task_id),
		.burst_total  (burst_total),
		.io_count     (io_count),
		.status_valid (status_valid),
		.status_stall (status_stall),
		.running_valid(running_valid),
		.running_id   (running_id),
		.running_class(running_class),
		.fore_empty   (fore_empty),
		.back_empty   (back_empty),
		.dropped      (dropped),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// scheduler state as the testbench sees it
	logic [TASK_ID_W-1:0] fore_ids [$];
	logic [TASK_ID_W-1:0] back_ids [$];
	bit                   task_is_fore [NUM_IDS];
	logic [TASK_ID_W-1:0] cur_task    = '0;
	logic                 cur_busy    = 1'b0;
	logic [SHARE_W-1:0]   share_turns = '0;
	logic [SLICE_W-1:0]   slice_ticks = '0;
	logic [THR_W-1:0]     long_thr    = THR_RESET;
	logic [SLICE_W-1:0]   slice_len   = SLICE_RESET;
	logic                 drop_now    = 1'b0;

	status_word_t status_backlog [$];
	bit [NUM_IDS-1:0] seen_ids      = '0;
	int               flood_left    = 0;
	bit               flood_fore    = 1'b0;
	int               sender_idle_pct = 0;
	int               stall_pct     = 0;
	bit               hold_request  = 1'b0;
	int               mismatch_count = 0;
	int               words_checked = 0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{'{OP_TICK,     4'd0,  16'd0,     4'd0},  1'b1, IDLE_ALL},
		'{'{OP_COMPLETE, 4'd0,  16'd0,     4'd0},  1'b1, IDLE_ALL},
		'{'{OP_BLOCK,    4'd0,  16'd0,     4'd0},  1'b1, IDLE_ALL},
		'{'{OP_SPARE_LO, 4'd0,  16'd0,     4'd0},  1'b1, IDLE_ALL},
		'{'{OP_SPARE_MID, 4'd5, 16'd100,   4'd3},  1'b1, IDLE_ALL},
		'{'{OP_SPARE_HI, 4'd15, 16'hffff,  4'd15}, 1'b1, IDLE_ALL},
		'{'{OP_ARRIVE,   4'd15, 16'hffff,  4'd0},  1'b1, '{1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{'{OP_ARRIVE,   4'd0,  16'd0,     4'd15}, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
		// burst right at and just above the threshold
		'{'{OP_ARRIVE,   4'd3,  16'd5,     4'd0},  1'b0, '0},
		'{'{OP_ARRIVE,   4'd4,  16'd6,     4'd0},  1'b0, '0},
		'{'{OP_ARRIVE,   4'd7,  16'd80,    4'd15}, 1'b0, '0},
		'{'{OP_TICK,     4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_TICK,     4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_TICK,     4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_BLOCK,    4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_REQUEUE,  4'd3,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_COMPLETE, 4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_COMPLETE, 4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_COMPLETE, 4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_TICK,     4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_REQUEUE,  4'd15, 16'd0,     4'd0},  1'b0, '0},
		'{'{OP_COMPLETE, 4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_BLOCK,    4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_TICK,     4'd0,  16'd0,     4'd0},  1'b0, '0},
		'{'{OP_ARRIVE,   4'd9,  16'd81,    4'd15}, 1'b0, '0}
	};

	function automatic void enqueue_task(input logic [TASK_ID_W-1:0] id);
		if (task_is_fore[id]) begin
			if (fore_ids.size() >= MAX_TASKS_DEF) drop_now = 1'b1;
			else fore_ids.push_back(id);
		end else begin
			if (back_ids.size() >= MAX_TASKS_DEF) drop_now = 1'b1;
			else back_ids.push_back(id);
		end
	endfunction

	function automatic void bump_share();
		if (task_is_fore[cur_task])
			share_turns = (share_turns == SHARE_LAST) ? '0 : share_turns + 3'd1;
		else
			share_turns = '0;
	endfunction

	function automatic void pick_task();
		slice_ticks = '0;
		cur_busy = 1'b1;
		if (share_turns < FORE_TURNS && fore_ids.size() > 0) cur_task = fore_ids.pop_front();
		else if (back_ids.size() > 0) cur_task = back_ids.pop_front();
		else if (fore_ids.size() > 0) cur_task = fore_ids.pop_front();
		else begin
			cur_busy = 1'b0;
			cur_task = '0;
		end
		if (cur_busy && !task_is_fore[cur_task]) share_turns = '0;
	endfunction

	function automatic void schedule_step(input sched_event_t e, output status_word_t s);
		logic fore_turn;
		drop_now = 1'b0;
		case (e.op)
			OP_ARRIVE: begin
				seen_ids[e.task_id] = 1'b1;
				task_is_fore[e.task_id] = !(e.burst_total > long_thr * (e.io_count + 32'd1));
				enqueue_task(e.task_id);
			end
			OP_REQUEUE: enqueue_task(e.task_id);
			OP_COMPLETE: if (cur_busy) begin
				share_turns = (share_turns == SHARE_LAST) ? '0 : share_turns + 3'd1;
				pick_task();
			end
			OP_BLOCK: if (cur_busy) begin
				bump_share();
				pick_task();
			end
			OP_TICK: begin
				if (!cur_busy) begin
					pick_task();
				end else if (slice_ticks == slice_len) begin
					bump_share();
					slice_ticks = '0;
					fore_turn = share_turns < FORE_TURNS;
					// rotate only when the queue of this turn has someone waiting
					if (fore_turn && fore_ids.size() > 0) begin
						enqueue_task(cur_task);
						cur_task = fore_ids.pop_front();
					end else if (!fore_turn && back_ids.size() > 0) begin
						enqueue_task(cur_task);
						cur_task = back_ids.pop_front();
					end
					if (!task_is_fore[cur_task]) share_turns = '0;
				end
				if (cur_busy) slice_ticks = slice_ticks + 8'd1;
			end
			default: ;
		endcase
		s.running_valid = cur_busy;
		s.running_id    = cur_busy ? cur_task : '0;
		s.running_class = cur_busy && task_is_fore[cur_task];
		s.fore_empty    = fore_ids.size() == 0;
		s.back_empty    = back_ids.size() == 0;
		s.dropped       = drop_now;
	endfunction

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("status word %0d at %0t: %s", words_checked, $time, what);
	endtask

	task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic apply_pace(input pace_t pace);
		sender_idle_pct = (pace == PACE_SENDER) ? 82 : (pace == PACE_BOTH) ? 6 : 0;
		stall_pct = (pace == PACE_RECEIVER) ? 82 : (pace == PACE_BOTH) ? 6 : 0;
	endtask

	task automatic set_config(input logic [THR_W-1:0] thr, input logic [SLICE_W-1:0] slice);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LONG_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_index <= REG_SLICE_LENGTH;
		cfg_data  <= {8'd0, slice};
		@(posedge clk);
		cfg_we <= 1'b0;
		long_thr  = thr;
		slice_len = slice;
	endtask

	// offer one event word and record its status once taken
	task automatic offer_event(input sched_event_t e, input logic typed,
			input status_word_t want);
		status_word_t predicted;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			event_valid <= 1'b0;
			@(posedge clk);
		end
		event_valid <= 1'b1;
		op          <= e.op;
		task_id     <= e.task_id;
		burst_total <= e.burst_total;
		io_count    <= e.io_count;
		do @(posedge clk); while (event_stall);
		schedule_step(e, predicted);
		status_backlog.push_back(typed ? want : predicted);
	endtask

	task automatic make_event(output sched_event_t e);
		int          pick;
		int unsigned lim;
		e.op          = OP_TICK;
		e.task_id     = 4'($urandom_range(0, NUM_IDS - 1));
		e.io_count    = 4'($urandom_range(0, 15));
		e.burst_total = 16'($urandom);
		if (flood_left == 0 && $urandom_range(0, 49) == 0) begin
			flood_left = $urandom_range(17, 20);
			flood_fore = 1'($urandom_range(0, 1));
		end
		pick = $urandom_range(0, 99);
		if (flood_left > 0) begin
			// burst of arrivals into one queue until it overflows
			flood_left--;
			e.op = OP_ARRIVE;
			if (flood_fore) begin
				e.burst_total = '0;
			end else begin
				e.io_count    = '0;
				e.burst_total = '1;
			end
		end else if (pick < 18 || (pick < 28 && seen_ids == '0)) begin
			e.op = OP_ARRIVE;
			if ($urandom_range(0, 1)) begin
				lim = long_thr * (e.io_count + 32'd1) + $urandom_range(0, 4);
				lim = (lim < 2) ? 0 : lim - 2;
				e.burst_total = (lim > 65535) ? '1 : 16'(lim);
			end
		end else if (pick < 28) begin
			e.op = OP_REQUEUE;
			while (!seen_ids[e.task_id]) e.task_id = 4'($urandom_range(0, NUM_IDS - 1));
		end else if (pick < 42) begin
			e.op = OP_COMPLETE;
		end else if (pick < 56) begin
			e.op = OP_BLOCK;
		end else if (pick >= 95) begin
			e.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		end
	endtask

	task automatic drain_backlog();
		event_valid <= 1'b0;
		while (status_backlog.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		sched_event_t e;
		repeat (count) begin
			make_event(e);
			offer_event(e, 1'b0, '0);
		end
		drain_backlog();
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : stimulus
		sched_event_t e;
		arst_n      <= 1'b0;
		event_valid <= 1'b0;
		op          <= OP_ARRIVE;
		task_id     <= '0;
		burst_total <= '0;
		io_count    <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_LONG_THRESHOLD;
		cfg_data    <= '0;
		apply_pace(PACE_NONE);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
		run_random(200);

		apply_pace(PACE_SENDER);
		set_config(16'd0, 8'd1);
		run_random(200);

		apply_pace(PACE_RECEIVER);
		set_config(16'hffff, 8'd255);
		run_random(200);

		// zero slice: the slice count wraps, so a rotation only after 256 ticks
		apply_pace(PACE_NONE);
		set_config(16'($urandom_range(0, 200)), 8'd0);
		e = '{OP_ARRIVE, 4'($urandom_range(0, 15)), 16'd0, 4'($urandom_range(0, 15))};
		offer_event(e, 1'b0, '0);
		e = '{OP_ARRIVE, 4'($urandom_range(0, 15)), 16'd0, 4'($urandom_range(0, 15))};
		offer_event(e, 1'b0, '0);
		e = '{OP_ARRIVE, 4'($urandom_range(0, 15)), 16'hffff, 4'd0};
		offer_event(e, 1'b0, '0);
		e = '{OP_TICK, 4'd0, 16'd0, 4'd0};
		repeat (262) offer_event(e, 1'b0, '0);
		run_random(30);

		// receiver holds off for a while so the status word backs up into the input
		apply_pace(PACE_BOTH);
		set_config(16'd20, 8'd3);
		hold_request = 1'b1;
		run_random(200);

		apply_pace(PACE_NONE);
		set_config(16'($urandom_range(1, 1000)), 8'($urandom_range(1, 8)));
		run_random(150);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && status_backlog.size() == 0)
			$display("two_level_queue_scheduler verification clean");
		else
			$display("two_level_queue_scheduler verification failed");
		$finish;
	end

	initial begin : status_sink
		int hold_left;
		hold_left = 0;
		status_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				status_stall <= 1'b1;
			end else begin
				status_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		status_word_t want;
		if (arst_n && status_valid && !status_stall) begin
			words_checked++;
			if (status_backlog.size() == 0) begin
				note_mismatch("status word with nothing expected");
			end else begin
				want = status_backlog.pop_front();
				check_field("running_valid", 4'(running_valid), 4'(want.running_valid));
				check_field("running_id", running_id, want.running_id);
				check_field("running_class", 4'(running_class), 4'(want.running_class));
				check_field("fore_empty", 4'(fore_empty), 4'(want.fore_empty));
				check_field("back_empty", 4'(back_empty), 4'(want.back_empty));
				check_field("dropped", 4'(dropped), 4'(want.dropped));
			end
		end
	end

	initial begin : watchdog
		#4_000_000;
		$display("two_level_queue_scheduler verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/tlqs_pkg.sv
src/tlqs_ram.sv
src/tlqs_ctrl.sv
src/tlqs_datapath.sv
src/two_level_queue_scheduler.sv
tb/tb_two_level_queue_scheduler.sv
